>>> rtl/clipped_sprite_blit_defines.svh
// assertion macros for the clipped sprite blit
`ifndef CLIPPED_SPRITE_BLIT_DEFINES_SVH
`define CLIPPED_SPRITE_BLIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked while out of reset
`define CSB_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication, checked while out of reset
`define CSB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CSB_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define CSB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/csb_pkg.sv
`timescale 1ns / 1ps

package csb_pkg;

	// signed width for clip arithmetic: covers sheet/screen sizes up to 1024 plus offsets
	localparam int CLIP_W = 13;

	// configuration port
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_DEST_X      = 3'd0;
	localparam logic [IDX_W-1:0] REG_DEST_Y      = 3'd1;
	localparam logic [IDX_W-1:0] REG_SRC_X       = 3'd2;
	localparam logic [IDX_W-1:0] REG_SRC_Y       = 3'd3;
	localparam logic [IDX_W-1:0] REG_RECT_WIDTH  = 3'd4;
	localparam logic [IDX_W-1:0] REG_RECT_HEIGHT = 3'd5;
	localparam logic [IDX_W-1:0] REG_KEYED_MODE  = 3'd6;

	typedef struct packed {
		logic [8:0] dest_x;
		logic [8:0] dest_y;
		logic [8:0] src_x;
		logic [8:0] src_y;
		logic [8:0] rect_width;
		logic [9:0] rect_height;
		logic       keyed_mode;
	} csb_cfg_t;

endpackage

>>> rtl/clipped_sprite_blit.sv
`timescale 1ns / 1ps
// clipped sprite blit: takes a tile sheet streamed in raster order, one pixel per request,
// counts its column and row (sheet_start forces column 0, row 0 for that pixel), and for
// each pixel inside the source rectangle after clipping to the screen emits one frame-buffer
// write with address screen row * SCREEN_WIDTH + screen column. in keyed mode zero pixels are dropped.
// one pixel is taken every cycle while the result side keeps up; each taken pixel passes
// through the input register, then the clip compare and address multiply into the result
// register. configure the registers over the apb port only while no pixel is in flight.
`include "clipped_sprite_blit_defines.svh"

module clipped_sprite_blit #(
	parameter int SCREEN_WIDTH = 240,
	parameter int SCREEN_HEIGHT = 192,
	parameter int SHEET_WIDTH = 320,
	parameter int SHEET_ROWS = 512
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [csb_pkg::PADDR_W-1:0] paddr,
	input  logic [csb_pkg::PDATA_W-1:0] pwdata,
	output logic [csb_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	// sheet pixel requests
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [15:0]                 pixel,
	input  logic                        sheet_start,
	// frame-buffer write requests
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [15:0]                 write_addr,
	output logic [15:0]                 write_data
);
	import csb_pkg::*;

	localparam int COL_W = $clog2(SHEET_WIDTH);
	localparam int ROW_W = $clog2(SHEET_ROWS);
	localparam int XD_W = $clog2(SCREEN_WIDTH);
	localparam int YD_W = $clog2(SCREEN_HEIGHT);

	csb_cfg_t cfg;

	// stage 1: the taken pixel and its sheet position
	logic             valid_s1;
	logic [15:0]      pixel_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;

	// result register
	logic        out_valid_q;
	logic [15:0] addr_q;
	logic [15:0] data_q;

	logic             in_take;
	logic             res_free;
	logic             s1_move;
	logic [COL_W-1:0] cur_col;
	logic [ROW_W-1:0] cur_row;
	logic [COL_W-1:0] col_state;
	logic             hit_x, hit_y, emit;
	logic [XD_W-1:0]  dst_x;
	logic [YD_W-1:0]  dst_y;
	logic [31:0]      addr_full;

	csb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake: the result register frees when empty or being taken,
	// and stage 1 frees when it can move into the result register
	assign res_free = !out_valid_q || !out_stall;
	assign s1_move = valid_s1 && res_free;
	assign in_stall = valid_s1 && !res_free;
	assign in_take = in_valid && !in_stall;

	csb_sheet_counter #(
		.SHEET_WIDTH (SHEET_WIDTH),
		.SHEET_ROWS  (SHEET_ROWS)
	) u_counter (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (in_take),
		.sheet_start (sheet_start),
		.cur_col     (cur_col),
		.cur_row     (cur_row),
		.col_state   (col_state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take || s1_move) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pixel_s1 <= pixel;
			col_s1 <= cur_col;
			row_s1 <= cur_row;
		end
	end

	// clip both axes against the current registers
	csb_clip_axis #(
		.LIMIT (SCREEN_WIDTH),
		.POS_W (COL_W)
	) u_clip_x (
		.dest (cfg.dest_x),
		.src  (cfg.src_x),
		.len  ({1'b0, cfg.rect_width}),
		.pos  (col_s1),
		.hit  (hit_x),
		.dst  (dst_x)
	);

	csb_clip_axis #(
		.LIMIT (SCREEN_HEIGHT),
		.POS_W (ROW_W)
	) u_clip_y (
		.dest (cfg.dest_y),
		.src  (cfg.src_y),
		.len  (cfg.rect_height),
		.pos  (row_s1),
		.hit  (hit_y),
		.dst  (dst_y)
	);

	// transparent pixel in keyed mode gives no write
	assign emit = hit_x && hit_y && !(cfg.keyed_mode && (pixel_s1 == 16'd0));
	assign addr_full = 32'(dst_y) * 32'(SCREEN_WIDTH) + 32'(dst_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= s1_move && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && res_free) begin
			addr_q <= addr_full[15:0];
			data_q <= pixel_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign write_addr = addr_q;
	assign write_data = data_q;

	// input only backs up behind a stalled, full result register
	`CSB_ASSERT_SAME(a_stall_cause, clk, arst_n, in_stall, valid_s1 && out_valid_q && out_stall)
	// a sheet start puts the pixel at the sheet origin
	`CSB_ASSERT_NEXT(a_start_origin, clk, arst_n, in_take && sheet_start,
		(col_s1 == '0) && (row_s1 == '0))
	// column counter stays inside the sheet
	`CSB_ASSERT_SAME(a_col_range, clk, arst_n, 1'b1, col_state <= COL_W'(SHEET_WIDTH - 1))

endmodule

>>> rtl/csb_regs.sv
`timescale 1ns / 1ps

module csb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [csb_pkg::PADDR_W-1:0] paddr,
	input  logic [csb_pkg::PDATA_W-1:0] pwdata,
	output logic [csb_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output csb_pkg::csb_cfg_t           cfg
);
	import csb_pkg::*;

	csb_cfg_t cfg_q;
	logic [IDX_W-1:0] idx;
	logic wr_en;

	assign pready = 1'b1;
	assign idx = paddr[PADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_DEST_X:      cfg_q.dest_x <= pwdata[8:0];
				REG_DEST_Y:      cfg_q.dest_y <= pwdata[8:0];
				REG_SRC_X:       cfg_q.src_x <= pwdata[8:0];
				REG_SRC_Y:       cfg_q.src_y <= pwdata[8:0];
				REG_RECT_WIDTH:  cfg_q.rect_width <= pwdata[8:0];
				REG_RECT_HEIGHT: cfg_q.rect_height <= pwdata[9:0];
				REG_KEYED_MODE:  cfg_q.keyed_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_DEST_X:      prdata = PDATA_W'(cfg_q.dest_x);
			REG_DEST_Y:      prdata = PDATA_W'(cfg_q.dest_y);
			REG_SRC_X:       prdata = PDATA_W'(cfg_q.src_x);
			REG_SRC_Y:       prdata = PDATA_W'(cfg_q.src_y);
			REG_RECT_WIDTH:  prdata = PDATA_W'(cfg_q.rect_width);
			REG_RECT_HEIGHT: prdata = PDATA_W'(cfg_q.rect_height);
			REG_KEYED_MODE:  prdata = PDATA_W'(cfg_q.keyed_mode);
			default:         prdata = '0;
		endcase
	end

endmodule

>>> rtl/csb_sheet_counter.sv
`timescale 1ns / 1ps

module csb_sheet_counter #(
	parameter int SHEET_WIDTH = 320,
	parameter int SHEET_ROWS = 512,
	localparam int COL_W = $clog2(SHEET_WIDTH),
	localparam int ROW_W = $clog2(SHEET_ROWS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             sheet_start,
	output logic [COL_W-1:0] cur_col,
	output logic [ROW_W-1:0] cur_row,
	output logic [COL_W-1:0] col_state
);
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// position of the request being taken now
	assign cur_col = sheet_start ? '0 : col_q;
	assign cur_row = sheet_start ? '0 : row_q;
	assign col_state = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (cur_col == COL_W'(SHEET_WIDTH - 1)) begin
				col_q <= '0;
				row_q <= (cur_row == ROW_W'(SHEET_ROWS - 1)) ? '0 : cur_row + 1'b1;
			end else begin
				col_q <= cur_col + 1'b1;
				row_q <= cur_row;
			end
		end
	end

endmodule

>>> rtl/csb_clip_axis.sv
`timescale 1ns / 1ps

module csb_clip_axis #(
	parameter int LIMIT = 240,
	parameter int POS_W = 9,
	localparam int DST_W = $clog2(LIMIT)
) (
	input  logic signed [8:0] dest,
	input  logic [8:0]        src,
	input  logic [9:0]        len,
	input  logic [POS_W-1:0]  pos,
	output logic              hit,
	output logic [DST_W-1:0]  dst
);
	import csb_pkg::*;

	localparam logic signed [CLIP_W-1:0] LIM_S = CLIP_W'(LIMIT);

	logic signed [CLIP_W-1:0] d_ext, s_ext, n_ext, p_ext;
	logic signed [CLIP_W-1:0] d_c, s_c, n_c, off, room, dst_full;

	always_comb begin
		d_ext = CLIP_W'(dest);
		s_ext = $signed(CLIP_W'(src));
		n_ext = $signed(CLIP_W'(len));
		p_ext = $signed(CLIP_W'(pos));
		// a negative edge moves the source start and shrinks the length
		if (d_ext < 0) begin
			s_c = s_ext - d_ext;
			n_c = n_ext + d_ext;
			d_c = '0;
		end else begin
			s_c = s_ext;
			n_c = n_ext;
			d_c = d_ext;
		end
		off = p_ext - s_c;
		room = LIM_S - d_c;
		// inside when the offset is non-negative and below both the length and the room to the far edge
		hit = (off >= 0) && (off < n_c) && (off < room);
		dst_full = d_c + off;
		dst = dst_full[DST_W-1:0];
	end

endmodule
